[design/rdwr_pkg.sv]
package rdwr_pkg;

  localparam int unsigned ACT_W    = 2;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned RND_W    = 31;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned BAG_DEPTH_DEF   = 64;
  localparam int unsigned RETRY_LIMIT_DEF = 500;
  localparam logic [CFG_W-1:0] CFG_RESET  = 7'd64;

  localparam logic [VAL_W-1:0] USED_MARK = 32'h7FFF_FFFF;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FILL  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DRAW  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_LOADED    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DRAWN     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_RETRY     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_TIMEOUT   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 3'd4;

  // The modulo unit retires this many dividend bits per cycle.
  localparam int unsigned MOD_RADIX = 8;
  localparam int unsigned MOD_STEPS = (RND_W + MOD_RADIX - 1) / MOD_RADIX;
  localparam int unsigned MOD_PAD_W = MOD_STEPS * MOD_RADIX;
  localparam int unsigned MOD_CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  typedef enum logic [2:0] {
    RDWR_IDLE,
    RDWR_FILL,
    RDWR_MOD,
    RDWR_READ,
    RDWR_CHECK
  } rdwr_state_t;

endpackage

[design/random_draw_without_replacement_core.sv]
// Shuffle-bag draw core. The bag of signed 32-bit entries lives in one synchronous RAM.
// Input channel: an item (in_action, in_index, in_value, in_random_value) is taken
// at a clock edge where start is high and busy is low.
// Result channel: every write, fill or draw item gives one word on out_status and
// out_drawn_value, shown for exactly one cycle with out_valid high; there is no
// back-pressure, the receiver must take it in that cycle. Action 3 gives no word.
// Config channel: cfg_data sets entry_count at an edge with cfg_valid and cfg_ready high;
// cfg_ready is always high. Write it only while the core is idle.
// Sequence, from the accepting edge to the result:
//   write: the result word follows in the next cycle; the next item may follow at once.
//   fill: one RAM write per effective entry, then the result word.
//   draw attempt: the modulo unit (8 bits of the random word per cycle) and its done
//   cycle, one RAM read and the check, which writes the used mark back on a hit;
//   an exhausted or timed-out attempt answers in the next cycle.
// Each item finishes before the next is taken; busy is high meanwhile.
// Reset (rst_n low, synchronous) clears the counts and the draw state and sets
// entry_count to 64; RAM contents are undefined until loaded.
module random_draw_without_replacement_core #(
  parameter int unsigned BAG_DEPTH   = rdwr_pkg::BAG_DEPTH_DEF,
  parameter int unsigned RETRY_LIMIT = rdwr_pkg::RETRY_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rdwr_pkg::ACT_W-1:0]          in_action,
  input  logic [rdwr_pkg::IDX_W-1:0]          in_index,
  input  logic signed [rdwr_pkg::VAL_W-1:0]   in_value,
  input  logic [rdwr_pkg::RND_W-1:0]          in_random_value,
  output logic                                out_valid,
  output logic [rdwr_pkg::STATUS_W-1:0]       out_status,
  output logic signed [rdwr_pkg::VAL_W-1:0]   out_drawn_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rdwr_pkg::CFG_W-1:0]          cfg_data
);

  import rdwr_pkg::*;

  localparam int unsigned AW   = $clog2(BAG_DEPTH);
  localparam int unsigned CLOG = $clog2(BAG_DEPTH + 1);
  localparam int unsigned CW   = (CLOG > CFG_W) ? CLOG : CFG_W;
  localparam int unsigned RW   = $clog2(RETRY_LIMIT + 1);

  rdwr_state_t state_r, state_nxt;

  logic [CFG_W-1:0]    cfg_r;
  logic [CW-1:0]       used_r, used_nxt;
  logic                active_r, active_nxt;
  logic [RW-1:0]       retries_r, retries_nxt;
  logic [AW-1:0]       fill_k_r, fill_k_nxt;
  logic [VAL_W-1:0]    fill_val_r, fill_val_nxt;
  logic [AW-1:0]       rd_addr_r, rd_addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [VAL_W-1:0]    out_value_r, out_value_nxt;

  logic [CW-1:0]    count;
  logic [RW-1:0]    ret_eff;
  logic             accept;
  logic             idx_ok;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;
  logic             mod_start;
  logic             mod_done;
  logic [CW-1:0]    mod_rem;

  assign count = (cfg_r == '0) ? CW'(1) :
                 (CW'(cfg_r) > CW'(BAG_DEPTH)) ? CW'(BAG_DEPTH) : CW'(cfg_r);
  assign ret_eff   = active_r ? retries_r : RW'(RETRY_LIMIT);
  assign busy      = (state_r != RDWR_IDLE);
  assign accept    = start && !busy;
  assign idx_ok    = (32'(in_index) < BAG_DEPTH);
  assign cfg_ready = 1'b1;

  rdwr_ram #(
    .WIDTH(VAL_W),
    .DEPTH(BAG_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rdwr_mod #(
    .CW(CW)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .dividend(in_random_value),
    .divisor (count),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= RDWR_IDLE;
      cfg_r       <= CFG_RESET;
      used_r      <= '0;
      active_r    <= 1'b0;
      retries_r   <= '0;
      fill_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      active_r    <= active_nxt;
      retries_r   <= retries_nxt;
      fill_k_r    <= fill_k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
    end
    fill_val_r   <= fill_val_nxt;
    rd_addr_r    <= rd_addr_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    active_nxt     = active_r;
    retries_nxt    = retries_r;
    fill_k_nxt     = fill_k_r;
    fill_val_nxt   = fill_val_r;
    rd_addr_nxt    = rd_addr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    ram_we         = 1'b0;
    ram_waddr      = fill_k_r;
    ram_wdata      = fill_val_r + VAL_W'(fill_k_r);
    ram_re         = 1'b0;
    ram_raddr      = AW'(mod_rem);
    mod_start      = 1'b0;

    case (state_r)
      RDWR_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_WRITE: begin
              ram_we         = idx_ok;
              ram_waddr      = AW'(in_index);
              ram_wdata      = in_value;
              used_nxt       = '0;
              active_nxt     = 1'b0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_LOADED;
              out_value_nxt  = '0;
            end
            ACT_FILL: begin
              fill_val_nxt = in_value;
              fill_k_nxt   = '0;
              state_nxt    = RDWR_FILL;
            end
            ACT_DRAW: begin
              if (!active_r && (used_r >= count)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EXHAUSTED;
                out_value_nxt  = USED_MARK;
              end else begin
                if (!active_r) begin
                  used_nxt = used_r + 1'b1;
                end
                if (ret_eff == '0) begin
                  active_nxt     = 1'b0;
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = STAT_TIMEOUT;
                  out_value_nxt  = USED_MARK;
                end else begin
                  active_nxt  = 1'b1;
                  retries_nxt = ret_eff - 1'b1;
                  mod_start   = 1'b1;
                  state_nxt   = RDWR_MOD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      RDWR_FILL: begin
        ram_we     = 1'b1;
        fill_k_nxt = fill_k_r + 1'b1;
        if (CW'(fill_k_r) == (count - 1'b1)) begin
          used_nxt       = '0;
          active_nxt     = 1'b0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_LOADED;
          out_value_nxt  = '0;
          state_nxt      = RDWR_IDLE;
        end
      end
      RDWR_MOD: begin
        if (mod_done) begin
          ram_re      = 1'b1;
          rd_addr_nxt = AW'(mod_rem);
          state_nxt   = RDWR_READ;
        end
      end
      RDWR_READ: begin
        state_nxt = RDWR_CHECK;
      end
      RDWR_CHECK: begin
        out_valid_nxt = 1'b1;
        if (ram_rdata != USED_MARK) begin
          ram_we         = 1'b1;
          ram_waddr      = rd_addr_r;
          ram_wdata      = USED_MARK;
          active_nxt     = 1'b0;
          out_status_nxt = STAT_DRAWN;
          out_value_nxt  = ram_rdata;
        end else begin
          out_status_nxt = STAT_RETRY;
          out_value_nxt  = '0;
        end
        state_nxt = RDWR_IDLE;
      end
      default: begin
        state_nxt = RDWR_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_drawn_value = out_value_r;

  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word shown while an item is still at work");

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(BAG_DEPTH))
    else $error("used count ran past the bag depth");

  a_read_then_check: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == RDWR_READ |=> state_r == RDWR_CHECK)
    else $error("RAM read data not consumed in the following cycle");

  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == RDWR_MOD)
    else $error("modulo result arrived outside a draw attempt");

  a_drawn_not_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_DRAWN) |-> out_drawn_value != USED_MARK)
    else $error("a used entry was handed out as drawn");

endmodule

[design/rdwr_ram.sv]
module rdwr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/rdwr_mod.sv]
module rdwr_mod #(
  parameter int unsigned CW = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rdwr_pkg::RND_W-1:0]  dividend,
  input  logic [CW-1:0]               divisor,
  output logic                        done,
  output logic [CW-1:0]               rem
);

  import rdwr_pkg::*;

  logic [MOD_PAD_W-1:0] sh_r;
  logic [CW-1:0]        rem_r;
  logic [CW-1:0]        rem_nxt;
  logic [CW-1:0]        div_r;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;

  // Restoring remainder, several bits per cycle; the partial remainder stays below the divisor.
  always_comb begin
    logic [CW:0] t;
    rem_nxt = rem_r;
    for (int i = 0; i < int'(MOD_RADIX); i++) begin
      t = {rem_nxt, sh_r[MOD_PAD_W-1-i]};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      rem_nxt = t[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        sh_r  <= MOD_PAD_W'(dividend);
        rem_r <= '0;
        div_r <= divisor;
        cnt_r <= MOD_CNT_W'(MOD_STEPS - 1);
        run_r <= 1'b1;
      end else if (run_r) begin
        sh_r  <= sh_r << MOD_RADIX;
        rem_r <= rem_nxt;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[dv/rdwr_bag_checker.sv]
`timescale 1ns / 1ps

module rdwr_bag_checker #(
  parameter int unsigned BAG_DEPTH   = rdwr_pkg::BAG_DEPTH_DEF,
  parameter int unsigned RETRY_LIMIT = rdwr_pkg::RETRY_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [rdwr_pkg::ACT_W-1:0]          in_action,
  input  logic [rdwr_pkg::IDX_W-1:0]          in_index,
  input  logic [rdwr_pkg::VAL_W-1:0]          in_value,
  input  logic [rdwr_pkg::RND_W-1:0]          in_random_value,
  input  logic                                out_valid,
  input  logic [rdwr_pkg::STATUS_W-1:0]       out_status,
  input  logic [rdwr_pkg::VAL_W-1:0]          out_drawn_value,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [rdwr_pkg::CFG_W-1:0]          cfg_data,
  output int                                  word_errors,
  output int                                  words_awaited
);
  import rdwr_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    value;
  } bag_word_t;

  logic [VAL_W-1:0] bag [BAG_DEPTH];
  logic [CFG_W-1:0] count_reg;
  int unsigned      draws_taken;
  bit               drawing;
  int unsigned      tries_left;
  bag_word_t        awaited_words [$];
  int               errors = 0;

  function automatic int unsigned live_count();
    if (count_reg == 0) return 1;
    if (count_reg > BAG_DEPTH) return BAG_DEPTH;
    return 32'(count_reg);
  endfunction

  task automatic apply_item(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] val, input logic [RND_W-1:0] rnd);
    int unsigned n;
    int unsigned i;
    int unsigned slot;
    bag_word_t   w;
    n = live_count();
    w.status = STAT_LOADED;
    w.value = '0;
    case (act)
      ACT_WRITE: begin
        if (idx < BAG_DEPTH) bag[idx] = val;
        draws_taken = 0;
        drawing = 1'b0;
      end
      ACT_FILL: begin
        for (i = 0; i < n; i++) bag[i] = val + i;
        draws_taken = 0;
        drawing = 1'b0;
      end
      ACT_DRAW: begin
        if (!drawing && draws_taken >= n) begin
          w.status = STAT_EXHAUSTED;
          w.value = USED_MARK;
        end else begin
          if (!drawing) begin
            draws_taken++;
            tries_left = RETRY_LIMIT;
            drawing = 1'b1;
          end
          if (tries_left == 0) begin
            drawing = 1'b0;
            w.status = STAT_TIMEOUT;
            w.value = USED_MARK;
          end else begin
            tries_left--;
            slot = rnd % n;
            if (bag[slot] != USED_MARK) begin
              w.status = STAT_DRAWN;
              w.value = bag[slot];
              bag[slot] = USED_MARK;
              drawing = 1'b0;
            end else begin
              w.status = STAT_RETRY;
            end
          end
        end
      end
      default: return;
    endcase
    awaited_words.push_back(w);
  endtask

  always @(posedge clk) begin : watch
    bag_word_t want;
    if (!rst_n) begin
      count_reg = CFG_RESET;
      draws_taken = 0;
      drawing = 1'b0;
      tries_left = 0;
      awaited_words.delete();
    end else begin
      if (out_valid) begin
        if (awaited_words.size() == 0) begin
          errors++;
          if (errors <= 100)
            $display("%0t: unexpected word, status %0d value %h", $time, out_status,
                     out_drawn_value);
        end else begin
          want = awaited_words.pop_front();
          if (out_status !== want.status) begin
            errors++;
            if (errors <= 100)
              $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          end
          if (out_drawn_value !== want.value) begin
            errors++;
            if (errors <= 100)
              $display("%0t: drawn_value expected %h actual %h", $time, want.value,
                       out_drawn_value);
          end
        end
      end
      if (cfg_valid && cfg_ready) count_reg = cfg_data;
      if (start && !busy) apply_item(in_action, in_index, in_value, in_random_value);
    end
    word_errors <= errors;
    words_awaited <= awaited_words.size();
  end

endmodule

[dv/random_draw_without_replacement_core_test.sv]
`timescale 1ns / 1ps

module random_draw_without_replacement_core_test;
  import rdwr_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
  localparam int unsigned ITEM_TARGET = 1350;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [ACT_W-1:0]     in_action;
  logic [IDX_W-1:0]     in_index;
  logic [VAL_W-1:0]     in_value;
  logic [RND_W-1:0]     in_random_value;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [VAL_W-1:0]     out_drawn_value;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data;
  int                   word_errors;
  int                   words_awaited;
  int unsigned          items_sent = 0;
  int unsigned          bag_size = BAG_DEPTH_DEF;
  bit                   steady = 1'b0;

  random_draw_without_replacement_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_index        (in_index),
    .in_value        (in_value),
    .in_random_value (in_random_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_drawn_value (out_drawn_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  rdwr_bag_checker bag_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_index        (in_index),
    .in_value        (in_value),
    .in_random_value (in_random_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_drawn_value (out_drawn_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .word_errors     (word_errors),
    .words_awaited   (words_awaited)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VAL_W-1:0] entry_value();
    logic [VAL_W-1:0] v;
    do v = $urandom; while (v == USED_MARK);
    return v;
  endfunction

  function automatic logic [VAL_W-1:0] fill_base();
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] d;
    do begin
      v = $urandom;
      d = USED_MARK - v;
    end while (d < bag_size);
    return v;
  endfunction

  task automatic send(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                      input logic [VAL_W-1:0] val, input logic [RND_W-1:0] rnd);
    int unsigned gap;
    in_action <= act;
    in_index <= idx;
    in_value <= val;
    in_random_value <= rnd;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (act != ACT_NONE) items_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    send(ACT_WRITE, idx, val, RND_W'($urandom));
  endtask

  task automatic fill_bag(input logic [VAL_W-1:0] val);
    send(ACT_FILL, IDX_W'($urandom), val, RND_W'($urandom));
  endtask

  task automatic draw(input logic [RND_W-1:0] rnd);
    send(ACT_DRAW, IDX_W'($urandom), $urandom, rnd);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (words_awaited != 0 || busy);
    repeat (80) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_count(input logic [CFG_W-1:0] c);
    settle();
    cfg_data <= c;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (c == 0) bag_size = 1;
    else if (c > BAG_DEPTH_DEF) bag_size = BAG_DEPTH_DEF;
    else bag_size = 32'(c);
  endtask

  task automatic drain_bag();
    int unsigned k;
    logic [31:0] hi;
    fill_bag(fill_base());
    repeat ($urandom_range(0, 3))
      write_entry(IDX_W'($urandom_range(0, bag_size - 1)), entry_value());
    repeat (bag_size + bag_size / 2 + 2) draw(RND_W'($urandom));
    for (k = 0; k < bag_size; k++) begin
      hi = (32'h7FFF_FFFF - k) / bag_size;
      draw(RND_W'(bag_size * $urandom_range(0, hi) + k));
    end
    repeat ($urandom_range(1, 2)) draw(RND_W'($urandom));
  endtask

  task automatic stir_bag();
    logic [ACT_W-1:0] act;
    repeat ($urandom_range(10, 30)) begin
      act = $urandom_range(0, 9) < 5 ? ACT_DRAW : ACT_W'($urandom);
      send(act, IDX_W'($urandom), ($urandom_range(0, 7) == 0) ? USED_MARK : $urandom,
           RND_W'($urandom));
    end
  endtask

  task automatic exhaust_retries();
    set_count(7'd2);
    fill_bag(fill_base());
    draw(31'd0);
    repeat (RETRY_LIMIT_DEF + 1) draw({30'($urandom_range(0, 32'h3FFF_FFFF)), 1'b0});
    draw(RND_W'($urandom));
  endtask

  initial begin
    int unsigned phase;
    logic [CFG_W-1:0] pick;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= ACT_WRITE;
    in_index <= '0;
    in_value <= '0;
    in_random_value <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= CFG_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fill_bag(32'h7FFF_FFFE);
    write_entry(6'd0, 32'h8000_0000);
    write_entry(6'd63, USED_MARK);
    write_entry(6'd5, 32'hFFFF_FFFF);
    draw(31'd0);
    draw(31'd1);
    draw(31'h7FFF_FFFF);
    draw(31'd5);
    draw(31'd1);
    write_entry(6'd1, 32'h0000_0000);
    draw(31'd65);
    send(ACT_NONE, IDX_W'($urandom), $urandom, RND_W'($urandom));
    draw(31'd2);
    draw(31'h4000_0000);
    set_count(7'd0);
    fill_bag(32'd10);
    draw(31'd12345);
    draw(RND_W'($urandom));
    set_count(7'd127);
    fill_bag(-32'sd100);
    draw(31'd127);
    draw(31'h7FFF_FFFF);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 4) == 0);
      if (phase == 3) begin
        exhaust_retries();
      end else begin
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 6))
            0: pick = 7'd0;
            1: pick = 7'd1;
            2: pick = 7'd2;
            3: pick = 7'd63;
            4: pick = 7'd64;
            5: pick = 7'd65;
            default: pick = 7'd127;
          endcase
        end else if ($urandom_range(0, 5) == 0) begin
          pick = CFG_W'($urandom_range(13, 64));
        end else begin
          pick = CFG_W'($urandom_range(1, 12));
        end
        set_count(pick);
        if ($urandom_range(0, 9) < 7) drain_bag();
        else stir_bag();
      end
      phase++;
    end
    steady = 1'b0;

    start <= 1'b0;
    phase = 0;
    do begin
      @(posedge clk);
      phase++;
    end while ((words_awaited != 0 || busy) && phase < 5000);
    repeat (80) @(posedge clk);
    if (word_errors == 0 && words_awaited == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
